FILE: hdl/kcs_pkg.sv
// Shared types and constants for the k-means color segmentation block.
package kcs_pkg;

  localparam int ChanW  = 8;
  localparam int ColorW = 24;
  localparam int SumW   = 29;
  localparam int CountW = 22;
  localparam int IdxW   = 3;
  localparam int CfgW   = 48;
  localparam int CfgIdxW = 3;
  localparam int Seeded = 7;

  localparam logic [CfgIdxW-1:0] RegBgEnable    = 3'd0;
  localparam logic [CfgIdxW-1:0] RegBgThreshold = 3'd1;
  localparam logic [CfgIdxW-1:0] RegSeedPairA   = 3'd2;
  localparam logic [CfgIdxW-1:0] RegSeedPairB   = 3'd3;
  localparam logic [CfgIdxW-1:0] RegSeedPairC   = 3'd4;
  localparam logic [CfgIdxW-1:0] RegSeedLast    = 3'd5;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_ACCUM,
    ST_OUT,
    ST_DIV
  } kcs_state_t;

  // Controller to datapath.
  typedef struct packed {
    logic capture;
    logic search_step;
    logic accumulate;
    logic div_start;
    logic div_step;
    logic div_next_cluster;
  } kcs_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic search_done;
    logic div_cluster_done;
    logic div_all_done;
  } kcs_status_t;

endpackage

FILE: hdl/kcs_if.sv
// Valid/ready stream interfaces for pixel input and result output.
interface kcs_pix_if;
  import kcs_pkg::*;
  logic valid;
  logic ready;
  logic [ChanW-1:0] pix_blue;
  logic [ChanW-1:0] pix_green;
  logic [ChanW-1:0] pix_red;
  logic [ChanW-1:0] bg_blue;
  logic [ChanW-1:0] bg_green;
  logic [ChanW-1:0] bg_red;
  logic frame_last;
  logic restart;
  modport source (output valid, pix_blue, pix_green, pix_red, bg_blue, bg_green, bg_red,
                  frame_last, restart, input ready);
  modport sink (input valid, pix_blue, pix_green, pix_red, bg_blue, bg_green, bg_red,
                frame_last, restart, output ready);
endinterface

interface kcs_res_if;
  import kcs_pkg::*;
  logic valid;
  logic ready;
  logic [ChanW-1:0] out_blue;
  logic [ChanW-1:0] out_green;
  logic [ChanW-1:0] out_red;
  logic [IdxW-1:0] cluster_index;
  logic foreground;
  modport source (output valid, out_blue, out_green, out_red, cluster_index, foreground,
                  input ready);
  modport sink (input valid, out_blue, out_green, out_red, cluster_index, foreground,
                output ready);
endinterface

FILE: hdl/kcs_ctrl.sv
// Controller state machine sequencing search, accumulate, output and frame update.
module kcs_ctrl
  import kcs_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_frame_last,
  output logic        out_valid,
  input  logic        out_ready,
  input  kcs_status_t status,
  output kcs_cmd_t    cmd
);

  kcs_state_t state, state_next;
  logic frame_end, frame_end_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      frame_end <= 1'b0;
    end else begin
      state <= state_next;
      frame_end <= frame_end_next;
    end
  end

  always_comb begin
    state_next = state;
    frame_end_next = frame_end;
    cmd = '0;
    in_ready = 1'b0;
    out_valid = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          frame_end_next = in_frame_last;
          state_next = ST_SEARCH;
        end
      end
      ST_SEARCH: begin
        cmd.search_step = 1'b1;
        if (status.search_done) state_next = ST_ACCUM;
      end
      ST_ACCUM: begin
        cmd.accumulate = 1'b1;
        state_next = ST_OUT;
      end
      ST_OUT: begin
        out_valid = 1'b1;
        if (out_ready) begin
          if (frame_end) begin
            cmd.div_start = 1'b1;
            state_next = ST_DIV;
          end else begin
            state_next = ST_IDLE;
          end
        end
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (status.div_cluster_done) begin
          cmd.div_next_cluster = 1'b1;
          if (status.div_all_done) state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

FILE: hdl/kcs_datapath.sv
// Datapath: centroid store, distance search, accumulators and mean divider.
module kcs_datapath
  import kcs_pkg::*;
#(
  parameter int Clusters = 7
)
(
  input  logic                clk,
  input  logic                rst,
  input  kcs_cmd_t            cmd,
  output kcs_status_t         status,
  input  logic                bg_enable,
  input  logic [ChanW-1:0]    bg_threshold,
  input  logic [ColorW-1:0]   seeds [Seeded],
  input  logic [ChanW-1:0]    pix [3],
  input  logic [ChanW-1:0]    bgp [3],
  input  logic                restart,
  output logic [ChanW-1:0]    res_color [3],
  output logic [IdxW-1:0]     res_index,
  output logic                res_fg
);

  localparam int KW = (Clusters > 1) ? $clog2(Clusters) : 1;
  localparam int DistW = 10;
  localparam int QW = 9;
  localparam logic [SumW-1:0] SumMax = {SumW{1'b1}};
  localparam logic [CountW-1:0] CountMax = {CountW{1'b1}};

  logic [ColorW-1:0] cent [Clusters];
  logic [SumW-1:0]   sums [Clusters][3];
  logic [CountW-1:0] counts [Clusters];

  logic [ChanW-1:0] px [3];
  logic             fg;
  logic [KW-1:0]    k;
  logic [KW-1:0]    sel;
  logic [DistW-1:0] best_d;
  logic             first;

  // Background test on the incoming pixel.
  logic fg_in;
  always_comb begin
    fg_in = 1'b0;
    for (int c = 0; c < 3; c++) begin
      if (((pix[c] > bgp[c]) ? pix[c] - bgp[c] : bgp[c] - pix[c]) > bg_threshold)
        fg_in = 1'b1;
    end
    if (!bg_enable) fg_in = 1'b1;
  end

  // L1 distance to centroid k.
  logic [DistW-1:0] l1_dist;
  always_comb begin
    l1_dist = '0;
    for (int c = 0; c < 3; c++) begin
      logic [ChanW-1:0] cc;
      cc = cent[k][c*ChanW +: ChanW];
      l1_dist = l1_dist + DistW'((cc > px[c]) ? cc - px[c] : px[c] - cc);
    end
  end

  // Restoring divider: one quotient bit per cycle per channel.
  logic [KW-1:0]     dk;
  logic [3:0]        dbit;
  logic [SumW-1:0]   rem [3];
  logic [SumW-1:0]   num [3];
  logic [QW-1:0]     quo [3];
  logic              qsat [3];

  assign status.search_done = (32'(k) == Clusters - 1);
  assign status.div_cluster_done = (counts[dk] == '0) || (dbit == 4'd0);
  assign status.div_all_done = (32'(dk) == Clusters - 1);

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < Clusters; i++) begin
        cent[i] <= '0;
        counts[i] <= '0;
        for (int c = 0; c < 3; c++) sums[i][c] <= '0;
      end
      k <= '0;
      dk <= '0;
      dbit <= '0;
    end else begin
      if (cmd.capture) begin
        fg <= fg_in;
        for (int c = 0; c < 3; c++) px[c] <= fg_in ? pix[c] : '0;
        k <= '0;
        first <= 1'b1;
        if (restart) begin
          for (int i = 0; i < Clusters; i++) begin
            cent[i] <= (i < Seeded) ? seeds[i] : '0;
            counts[i] <= '0;
            for (int c = 0; c < 3; c++) sums[i][c] <= '0;
          end
        end
      end
      if (cmd.search_step) begin
        if (first || l1_dist < best_d) begin
          best_d <= l1_dist;
          sel <= k;
        end
        first <= 1'b0;
        if (!status.search_done) k <= k + 1'b1;
      end
      if (cmd.accumulate) begin
        for (int c = 0; c < 3; c++) begin
          logic [SumW:0] s;
          s = {1'b0, sums[sel][c]} + (SumW+1)'(px[c]);
          sums[sel][c] <= s[SumW] ? SumMax : s[SumW-1:0];
          res_color[c] <= cent[sel][c*ChanW +: ChanW];
        end
        if (counts[sel] != CountMax) counts[sel] <= counts[sel] + 1'b1;
        res_index <= IdxW'(sel);
        res_fg <= fg;
      end
      if (cmd.div_start) begin
        dk <= '0;
        dbit <= 4'(QW + 1);
        for (int c = 0; c < 3; c++) begin
          num[c] <= sums[0][c];
          rem[c] <= '0;
          qsat[c] <= 1'b0;
        end
      end else if (cmd.div_step) begin
        if (cmd.div_next_cluster) begin
          if (counts[dk] != '0) begin
            cent[dk] <= {qsat[2] || quo[2] > 9'd255 ? 8'hFF : quo[2][7:0],
                         qsat[1] || quo[1] > 9'd255 ? 8'hFF : quo[1][7:0],
                         qsat[0] || quo[0] > 9'd255 ? 8'hFF : quo[0][7:0]};
          end
          counts[dk] <= '0;
          for (int c = 0; c < 3; c++) sums[dk][c] <= '0;
          if (!status.div_all_done) begin
            dk <= dk + 1'b1;
            dbit <= 4'(QW + 1);
            for (int c = 0; c < 3; c++) begin
              num[c] <= sums[dk + 1'b1][c];
              rem[c] <= '0;
              qsat[c] <= 1'b0;
            end
          end
        end else if (dbit == 4'(QW + 1)) begin
          // Quotient of at least 512 means clamp; otherwise 9 bits suffice.
          for (int c = 0; c < 3; c++) begin
            qsat[c] <= (num[c] >> QW) >= SumW'(counts[dk]);
            rem[c] <= num[c] >> QW;
            num[c] <= num[c] << (SumW - QW);
          end
          dbit <= dbit - 1'b1;
        end else begin
          for (int c = 0; c < 3; c++) begin
            logic [SumW:0] t;
            t = {rem[c], num[c][SumW-1]};
            if (t >= (SumW+1)'(counts[dk])) begin
              rem[c] <= SumW'(t - (SumW+1)'(counts[dk]));
              quo[c] <= {quo[c][QW-2:0], 1'b1};
            end else begin
              rem[c] <= t[SumW-1:0];
              quo[c] <= {quo[c][QW-2:0], 1'b0};
            end
            num[c] <= num[c] << 1;
          end
          dbit <= dbit - 1'b1;
        end
      end
    end
  end

endmodule

FILE: hdl/kmeans_color_segmentation_core.sv
// Top level of the k-means color segmentation block.
// Each pixel is captured, compared with all Clusters centroids, accumulated, then offered.
// A new pixel is accepted only after the result of the last one has been taken.
// After the result of a pixel marked frame_last is taken, the mean update runs cluster by
// cluster in a shared restoring divider. Synchronous active-high reset clears the control
// state, configuration registers, centroids, sums and counts; bg_threshold resets to 50.
module kmeans_color_segmentation_core
  import kcs_pkg::*;
#(
  parameter int Clusters = 7
)
(
  input  logic            clk,
  input  logic            rst,
  kcs_pix_if.sink         pix_in,
  kcs_res_if.source       res_out,
  input  logic            cfg_we,
  input  logic [CfgIdxW-1:0] cfg_index,
  input  logic [CfgW-1:0] cfg_data
);

  logic               bg_enable;
  logic [ChanW-1:0]   bg_threshold;
  logic [CfgW-1:0]    seed_a, seed_b, seed_c;
  logic [ColorW-1:0]  seed_l;

  always_ff @(posedge clk) begin
    if (rst) begin
      bg_enable <= 1'b0;
      bg_threshold <= 8'd50;
      seed_a <= '0;
      seed_b <= '0;
      seed_c <= '0;
      seed_l <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        RegBgEnable:    bg_enable <= cfg_data[0];
        RegBgThreshold: bg_threshold <= cfg_data[ChanW-1:0];
        RegSeedPairA:   seed_a <= cfg_data;
        RegSeedPairB:   seed_b <= cfg_data;
        RegSeedPairC:   seed_c <= cfg_data;
        RegSeedLast:    seed_l <= cfg_data[ColorW-1:0];
        default: ;
      endcase
    end
  end

  logic [ColorW-1:0] seeds [Seeded];
  assign seeds[0] = seed_a[ColorW-1:0];
  assign seeds[1] = seed_a[CfgW-1:ColorW];
  assign seeds[2] = seed_b[ColorW-1:0];
  assign seeds[3] = seed_b[CfgW-1:ColorW];
  assign seeds[4] = seed_c[ColorW-1:0];
  assign seeds[5] = seed_c[CfgW-1:ColorW];
  assign seeds[6] = seed_l;

  logic [ChanW-1:0] pix [3];
  logic [ChanW-1:0] bgp [3];
  logic [ChanW-1:0] res_color [3];
  assign pix[0] = pix_in.pix_blue;
  assign pix[1] = pix_in.pix_green;
  assign pix[2] = pix_in.pix_red;
  assign bgp[0] = pix_in.bg_blue;
  assign bgp[1] = pix_in.bg_green;
  assign bgp[2] = pix_in.bg_red;
  assign res_out.out_blue  = res_color[0];
  assign res_out.out_green = res_color[1];
  assign res_out.out_red   = res_color[2];

  kcs_cmd_t    cmd;
  kcs_status_t status;

  kcs_ctrl u_ctrl (
    .clk, .rst,
    .in_valid(pix_in.valid), .in_ready(pix_in.ready), .in_frame_last(pix_in.frame_last),
    .out_valid(res_out.valid), .out_ready(res_out.ready),
    .status, .cmd
  );

  kcs_datapath #(.Clusters(Clusters)) u_dp (
    .clk, .rst, .cmd, .status,
    .bg_enable, .bg_threshold, .seeds, .pix, .bgp,
    .restart(pix_in.restart),
    .res_color, .res_index(res_out.cluster_index), .res_fg(res_out.foreground)
  );

  // An input transfer and a pending result never overlap.
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(pix_in.valid && pix_in.ready && res_out.valid))
    else $error("input accepted while a result is pending");

  // The result's cluster index holds while stalled.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    res_out.valid && !res_out.ready |=> $stable(res_out.cluster_index))
    else $error("result changed under stall");

  // With background removal off, every pixel is foreground.
  a_fg: assert property (@(posedge clk) disable iff (rst)
    res_out.valid && !bg_enable |-> res_out.foreground)
    else $error("background flag set while removal is off");

endmodule
